[hdl/jsjc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jsjc_pkg
// Shared types, register indexes, reset values and joystick zone decoding
// for the joystick servo jog controller.
// ----------------------------------------------------------------------------
package jsjc_pkg;

  localparam int NUM_SERVOS     = 7;
  localparam int OUT_W          = 12;
  localparam int CFG_W          = 12;
  localparam int STEP_W         = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int PULSE_BITS_DEF = 12;

  // Servo slots in the pulse array.
  localparam int SRV_ARM_LEFT   = 0;
  localparam int SRV_ARM_RIGHT  = 1;
  localparam int SRV_BASE_TURN  = 2;
  localparam int SRV_ELBOW      = 3;
  localparam int SRV_WRIST_TILT = 4;
  localparam int SRV_WRIST_TURN = 5;
  localparam int SRV_GRIPPER    = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_PULSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRIPPER_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRIPPER_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUGH_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP    = 3'd6;

  // Reset values.
  localparam logic [CFG_W-1:0]  CENTER_RST       = 12'd1500;
  localparam logic [CFG_W-1:0]  PULSE_MIN_RST    = 12'd600;
  localparam logic [CFG_W-1:0]  PULSE_MAX_RST    = 12'd2400;
  localparam logic [CFG_W-1:0]  GRIPPER_LOW_RST  = 12'h3A6;
  localparam logic [CFG_W-1:0]  GRIPPER_HIGH_RST = 12'h690;
  localparam logic [STEP_W-1:0] ROUGH_STEP_RST   = 8'd4;
  localparam logic [STEP_W-1:0] FINE_STEP_RST    = 8'd2;

  // Joystick zone edges.
  localparam logic [7:0] DZ_LO    = 8'h78;  // 120
  localparam logic [7:0] DZ_HI    = 8'h87;  // 135
  localparam logic [7:0] X_HI     = 8'd135;
  localparam logic [7:0] X_LO     = 8'd120;
  localparam logic [7:0] Y_HI     = 8'd140;
  localparam logic [7:0] Y_LO     = 8'd115;
  localparam logic [7:0] GAP_180  = 8'd180;
  localparam logic [7:0] GAP_210  = 8'd210;
  localparam logic [7:0] GAP_85   = 8'd85;
  localparam logic [7:0] GAP_55   = 8'd55;

  // Button byte bits.
  localparam int BTN_ARM_UP    = 0;
  localparam int BTN_TURN_UP   = 1;
  localparam int BTN_ARM_DOWN  = 2;
  localparam int BTN_TURN_DOWN = 3;
  localparam int BTN_E4        = 4;
  localparam int BTN_E5        = 5;
  localparam int BTN_CLOSE     = 6;

  typedef enum logic [2:0] {
    POS_X   = 3'b001,
    POS_Y   = 3'b010,
    POS_BTN = 3'b100
  } pos_t;

  typedef struct packed {
    logic [CFG_W-1:0]  pulse_min;
    logic [CFG_W-1:0]  pulse_max;
    logic [CFG_W-1:0]  gripper_low;
    logic [CFG_W-1:0]  gripper_high;
    logic [STEP_W-1:0] rough_step;
    logic [STEP_W-1:0] fine_step;
  } cfg_t;

  // Signed step for one joystick axis byte.
  function automatic logic signed [8:0] axis_delta(
    input logic [7:0]        b,
    input logic [7:0]        hi_edge,
    input logic [7:0]        lo_edge,
    input logic [STEP_W-1:0] fine,
    input logic [STEP_W-1:0] rough
  );
    logic signed [8:0] f9;
    logic signed [8:0] h9;
    logic signed [8:0] r9;
    logic signed [8:0] d;
    f9 = $signed({1'b0, fine});
    h9 = $signed({2'b00, fine[STEP_W-1:1]});
    r9 = $signed({1'b0, rough});
    d  = '0;
    if (b > DZ_LO && b < DZ_HI) begin
      d = '0;
    end else if (b > hi_edge) begin
      if (b < GAP_180)                     d = -h9;
      else if (b > GAP_180 && b < GAP_210) d = -f9;
      else if (b > GAP_210)                d = -r9;
      else                                 d = '0;
    end else if (b > GAP_85 && b < lo_edge) begin
      d = h9;
    end else if (b > GAP_55 && b < GAP_85) begin
      d = f9;
    end else if (b < GAP_55) begin
      d = r9;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

[hdl/jsjc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jsjc_in_if / jsjc_out_if
// Valid/ready channels for received bytes and for servo pulse results.
// ----------------------------------------------------------------------------
interface jsjc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface jsjc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] arm_left_pulse;
  logic [11:0] arm_right_pulse;
  logic [11:0] base_turn_pulse;
  logic [11:0] elbow_pulse;
  logic [11:0] wrist_tilt_pulse;
  logic [11:0] wrist_turn_pulse;
  logic [11:0] gripper_pulse;

  modport source (output valid, output arm_left_pulse, output arm_right_pulse,
                  output base_turn_pulse, output elbow_pulse,
                  output wrist_tilt_pulse, output wrist_turn_pulse,
                  output gripper_pulse, input ready);
  modport sink   (input valid, input arm_left_pulse, input arm_right_pulse,
                  input base_turn_pulse, input elbow_pulse,
                  input wrist_tilt_pulse, input wrist_turn_pulse,
                  input gripper_pulse, output ready);
endinterface
`default_nettype wire

[hdl/jsjc_frame_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jsjc_frame_update
// Next servo pulse widths for one complete frame (X, Y, buttons).
// ----------------------------------------------------------------------------
module jsjc_frame_update #(
  parameter int PULSE_BITS = jsjc_pkg::PULSE_BITS_DEF
) (
  input  wire jsjc_pkg::cfg_t                                     cfg,
  input  wire logic [7:0]                                         x_byte,
  input  wire logic [7:0]                                         y_byte,
  input  wire logic [7:0]                                         btn,
  input  wire logic [jsjc_pkg::NUM_SERVOS-1:0][PULSE_BITS-1:0]    servo_cur,
  output logic      [jsjc_pkg::NUM_SERVOS-1:0][PULSE_BITS-1:0]    servo_nxt
);

  localparam int SUM_W = PULSE_BITS + 2;

  logic signed [8:0]       rough9;
  logic signed [8:0]       dx;
  logic signed [8:0]       dy;
  logic signed [SUM_W-1:0] g_sum;
  logic                    e4;
  logic                    e5;

  function automatic logic signed [SUM_W-1:0] add_step(
    input logic [PULSE_BITS-1:0] cur,
    input logic signed [8:0]     d
  );
    return $signed({2'b00, cur}) + SUM_W'(d);
  endfunction

  function automatic logic fits(
    input logic signed [SUM_W-1:0]     v,
    input logic [jsjc_pkg::CFG_W-1:0]  lo,
    input logic [jsjc_pkg::CFG_W-1:0]  hi
  );
    return (v >= $signed(SUM_W'(lo))) && (v <= $signed(SUM_W'(hi)));
  endfunction

  // Apply a step; keep the old width when the result leaves the limits.
  function automatic logic [PULSE_BITS-1:0] jog(
    input logic [PULSE_BITS-1:0]      cur,
    input logic signed [8:0]          d,
    input logic [jsjc_pkg::CFG_W-1:0] lo,
    input logic [jsjc_pkg::CFG_W-1:0] hi
  );
    logic signed [SUM_W-1:0] s;
    s = add_step(cur, d);
    return fits(s, lo, hi) ? s[PULSE_BITS-1:0] : cur;
  endfunction

  always_comb begin
    rough9 = $signed({1'b0, cfg.rough_step});
    e4     = btn[jsjc_pkg::BTN_E4];
    e5     = btn[jsjc_pkg::BTN_E5];
    dx     = jsjc_pkg::axis_delta(x_byte, jsjc_pkg::X_HI, jsjc_pkg::X_LO,
                                  cfg.fine_step, cfg.rough_step);
    dy     = jsjc_pkg::axis_delta(y_byte, jsjc_pkg::Y_HI, jsjc_pkg::Y_LO,
                                  cfg.fine_step, cfg.rough_step);
    g_sum  = '0;
    servo_nxt = servo_cur;

    // Main arm pair: up wins over down.
    if (btn[jsjc_pkg::BTN_ARM_UP]) begin
      servo_nxt[jsjc_pkg::SRV_ARM_LEFT]  = jog(servo_cur[jsjc_pkg::SRV_ARM_LEFT], rough9,
                                               cfg.pulse_min, cfg.pulse_max);
      servo_nxt[jsjc_pkg::SRV_ARM_RIGHT] = jog(servo_cur[jsjc_pkg::SRV_ARM_RIGHT], rough9,
                                               cfg.pulse_min, cfg.pulse_max);
    end else if (btn[jsjc_pkg::BTN_ARM_DOWN]) begin
      servo_nxt[jsjc_pkg::SRV_ARM_LEFT]  = jog(servo_cur[jsjc_pkg::SRV_ARM_LEFT], -rough9,
                                               cfg.pulse_min, cfg.pulse_max);
      servo_nxt[jsjc_pkg::SRV_ARM_RIGHT] = jog(servo_cur[jsjc_pkg::SRV_ARM_RIGHT], -rough9,
                                               cfg.pulse_min, cfg.pulse_max);
    end

    if (btn[jsjc_pkg::BTN_TURN_UP]) begin
      servo_nxt[jsjc_pkg::SRV_BASE_TURN] = jog(servo_cur[jsjc_pkg::SRV_BASE_TURN], rough9,
                                               cfg.pulse_min, cfg.pulse_max);
    end else if (btn[jsjc_pkg::BTN_TURN_DOWN]) begin
      servo_nxt[jsjc_pkg::SRV_BASE_TURN] = jog(servo_cur[jsjc_pkg::SRV_BASE_TURN], -rough9,
                                               cfg.pulse_min, cfg.pulse_max);
    end

    // Gripper: close on its own button, open on both elbow buttons together.
    if (btn[jsjc_pkg::BTN_CLOSE]) begin
      g_sum = add_step(servo_cur[jsjc_pkg::SRV_GRIPPER], -rough9);
      if (g_sum > $signed(SUM_W'(cfg.gripper_low)) &&
          fits(g_sum, cfg.pulse_min, cfg.pulse_max)) begin
        servo_nxt[jsjc_pkg::SRV_GRIPPER] = g_sum[PULSE_BITS-1:0];
      end
    end else if (e4 && e5) begin
      g_sum = add_step(servo_cur[jsjc_pkg::SRV_GRIPPER], rough9);
      if (g_sum < $signed(SUM_W'(cfg.gripper_high)) &&
          fits(g_sum, cfg.pulse_min, cfg.pulse_max)) begin
        servo_nxt[jsjc_pkg::SRV_GRIPPER] = g_sum[PULSE_BITS-1:0];
      end
    end

    if (e4 && !e5) begin
      servo_nxt[jsjc_pkg::SRV_ELBOW] = jog(servo_cur[jsjc_pkg::SRV_ELBOW], rough9,
                                           cfg.pulse_min, cfg.pulse_max);
    end else if (e5 && !e4) begin
      servo_nxt[jsjc_pkg::SRV_ELBOW] = jog(servo_cur[jsjc_pkg::SRV_ELBOW], -rough9,
                                           cfg.pulse_min, cfg.pulse_max);
    end

    if (dx != 9'sd0) begin
      servo_nxt[jsjc_pkg::SRV_WRIST_TILT] = jog(servo_cur[jsjc_pkg::SRV_WRIST_TILT], dx,
                                                cfg.pulse_min, cfg.pulse_max);
    end
    if (dy != 9'sd0) begin
      servo_nxt[jsjc_pkg::SRV_WRIST_TURN] = jog(servo_cur[jsjc_pkg::SRV_WRIST_TURN], dy,
                                                cfg.pulse_min, cfg.pulse_max);
    end
  end

endmodule
`default_nettype wire

[hdl/joystick_servo_jog_controller_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_servo_jog_controller_top
// Frames serial bytes (X, Y, buttons) and jogs seven servo pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan   : one received byte per request; frames run X axis, Y axis,
//               button byte. The first two bytes of a frame give no result.
//   out_chan  : one request per frame, carrying all seven pulse widths after
//               the button byte has been applied.
//   cfg_*     : write-only registers, written while the block is idle.
//   Path      : input register -> frame update logic -> result register; a
//               button byte is applied once the result slot is free.
//   Throughput: one byte per cycle unless a button byte waits for that slot,
//               set by the single registered update path.
//   Reset     : byte position returns to X, the axis bytes clear, all servos
//               load the center width 1500 and all limits and steps take
//               their default values.
//   Stall     : a waiting result holds in the result register; X and Y bytes
//               keep flowing, and a button byte waits in the input register
//               until the result slot frees, which drops in_chan.ready.
//   The center register is write-accepted but only the reset value of the
//   servos matters, and reset reloads that value as well.
// ----------------------------------------------------------------------------
module joystick_servo_jog_controller_top #(
  parameter int PULSE_BITS = jsjc_pkg::PULSE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  jsjc_in_if.sink                                in_chan,
  jsjc_out_if.source                             out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [jsjc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [jsjc_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int NS = jsjc_pkg::NUM_SERVOS;
  localparam int OW = jsjc_pkg::OUT_W;

  // Configuration.
  jsjc_pkg::cfg_t cfg_r;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Frame state.
  jsjc_pkg::pos_t pos_r, pos_nxt;
  logic [7:0]     x_r;
  logic [7:0]     y_r;
  logic [NS-1:0][PULSE_BITS-1:0] servo_r;
  logic [NS-1:0][PULSE_BITS-1:0] servo_nxt;

  // Result register.
  logic                 out_valid_r;
  logic [NS-1:0][OW-1:0] out_pulse_r;

  logic s1_is_btn;
  logic out_free;
  logic s1_fire;
  logic in_take;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min    <= jsjc_pkg::PULSE_MIN_RST;
      cfg_r.pulse_max    <= jsjc_pkg::PULSE_MAX_RST;
      cfg_r.gripper_low  <= jsjc_pkg::GRIPPER_LOW_RST;
      cfg_r.gripper_high <= jsjc_pkg::GRIPPER_HIGH_RST;
      cfg_r.rough_step   <= jsjc_pkg::ROUGH_STEP_RST;
      cfg_r.fine_step    <= jsjc_pkg::FINE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jsjc_pkg::CFG_PULSE_MIN:    cfg_r.pulse_min    <= cfg_wdata;
        jsjc_pkg::CFG_PULSE_MAX:    cfg_r.pulse_max    <= cfg_wdata;
        jsjc_pkg::CFG_GRIPPER_LOW:  cfg_r.gripper_low  <= cfg_wdata;
        jsjc_pkg::CFG_GRIPPER_HIGH: cfg_r.gripper_high <= cfg_wdata;
        jsjc_pkg::CFG_ROUGH_STEP:   cfg_r.rough_step   <= cfg_wdata[jsjc_pkg::STEP_W-1:0];
        jsjc_pkg::CFG_FINE_STEP:    cfg_r.fine_step    <= cfg_wdata[jsjc_pkg::STEP_W-1:0];
        // Center width and unused indexes: nothing to hold.
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  // Any byte that is not an axis byte counts as the button byte.
  assign s1_is_btn = !(pos_r == jsjc_pkg::POS_X || pos_r == jsjc_pkg::POS_Y);
  assign out_free  = !out_valid_r || out_chan.ready;
  // Axis bytes never need the result slot; only the button byte waits on it.
  assign s1_fire   = s1_valid_r && (!s1_is_btn || out_free);
  assign in_take   = !s1_valid_r || s1_fire;

  assign in_chan.ready = in_take;

  always_comb begin
    case (pos_r)
      jsjc_pkg::POS_X: pos_nxt = jsjc_pkg::POS_Y;
      jsjc_pkg::POS_Y: pos_nxt = jsjc_pkg::POS_BTN;
      default:         pos_nxt = jsjc_pkg::POS_X;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_chan.rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Frame update
  // --------------------------------------------------------------------------
  jsjc_frame_update #(
    .PULSE_BITS (PULSE_BITS)
  ) u_update (
    .cfg       (cfg_r),
    .x_byte    (x_r),
    .y_byte    (y_r),
    .btn       (s1_byte_r),
    .servo_cur (servo_r),
    .servo_nxt (servo_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= jsjc_pkg::POS_X;
      x_r   <= '0;
      y_r   <= '0;
      for (int i = 0; i < NS; i++) begin
        servo_r[i] <= PULSE_BITS'(jsjc_pkg::CENTER_RST);
      end
    end else if (s1_fire) begin
      pos_r <= pos_nxt;
      case (pos_r)
        jsjc_pkg::POS_X: x_r <= s1_byte_r;
        jsjc_pkg::POS_Y: y_r <= s1_byte_r;
        default:         servo_r <= servo_nxt;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_is_btn) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_btn) begin
      for (int i = 0; i < NS; i++) begin
        out_pulse_r[i] <= OW'(servo_nxt[i]);
      end
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.arm_left_pulse   = out_pulse_r[jsjc_pkg::SRV_ARM_LEFT];
  assign out_chan.arm_right_pulse  = out_pulse_r[jsjc_pkg::SRV_ARM_RIGHT];
  assign out_chan.base_turn_pulse  = out_pulse_r[jsjc_pkg::SRV_BASE_TURN];
  assign out_chan.elbow_pulse      = out_pulse_r[jsjc_pkg::SRV_ELBOW];
  assign out_chan.wrist_tilt_pulse = out_pulse_r[jsjc_pkg::SRV_WRIST_TILT];
  assign out_chan.wrist_turn_pulse = out_pulse_r[jsjc_pkg::SRV_WRIST_TURN];
  assign out_chan.gripper_pulse    = out_pulse_r[jsjc_pkg::SRV_GRIPPER];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A button byte that leaves the input register always yields a result.
  a_btn_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_is_btn |=> out_valid_r)
    else $error("button byte applied without a result");

  // An axis byte never creates a result on its own.
  a_axis_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_is_btn |=> out_valid_r == $past(out_valid_r && !out_chan.ready))
    else $error("axis byte changed result valid");

  // Input back-pressure only comes from a stalled result and a waiting button.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_take |-> s1_valid_r && s1_is_btn && out_valid_r && !out_chan.ready)
    else $error("input stalled without cause");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Joystick servo jog controller testbench
// Streams serial bytes into the controller in X / Y / button frames and
// checks every returned set of seven pulse widths against a cycle-free
// prediction of the frame update. Register settings change between phases,
// and both channel sides idle or stall at random in some of the phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jsjc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  // Seven widths of one result, indexed by the package servo slots.
  typedef logic [NUM_SERVOS-1:0][OUT_W-1:0] pulse_set_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  jsjc_in_if in_chan ();
  jsjc_out_if out_chan ();

  joystick_servo_jog_controller_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared stimulus / scoreboard state
  // --------------------------------------------------------------------------
  logic [7:0] bytes_pending [$];    // bytes waiting for the driver
  pulse_set_t pulse_sets_due [$];   // predicted widths, oldest first
  bit byte_taken;                   // set at the edge that accepts a request
  bit sender_hold;                  // park the sender between requests
  int send_idle_pct;
  int ready_stall_pct;
  int failures;
  int bytes_seen;
  int frames_checked;
  int settings_used;
  int cycle_count;

  // Joystick values around every zone edge, to land on the exact gaps often.
  logic [7:0] axis_edges [26] = '{
    8'd0, 8'd54, 8'd55, 8'd56, 8'd84, 8'd85, 8'd86, 8'd114, 8'd115, 8'd116,
    8'd119, 8'd120, 8'd121, 8'd134, 8'd135, 8'd136, 8'd139, 8'd140, 8'd141,
    8'd179, 8'd180, 8'd181, 8'd209, 8'd210, 8'd211, 8'd255
  };

  string pulse_names [NUM_SERVOS] = '{
    "arm_left_pulse", "arm_right_pulse", "base_turn_pulse", "elbow_pulse",
    "wrist_tilt_pulse", "wrist_turn_pulse", "gripper_pulse"
  };

  // --------------------------------------------------------------------------
  // Frame predictor: its own copy of the registers and the servo widths.
  // --------------------------------------------------------------------------
  cfg_t lim;
  logic [CFG_W-1:0] center_setting;   // only matters at reset
  int byte_slot;                       // 0 = X, 1 = Y, 2 = buttons
  logic [7:0] x_held;
  logic [7:0] y_held;
  logic [OUT_W-1:0] servo_now [NUM_SERVOS];

  // Write a width only if it lands inside the pulse limits. Arithmetic is
  // signed int, so a step that goes below zero simply fails the lower limit.
  function automatic void store_width(int idx, int v);
    if (v > int'(lim.pulse_max) || v < int'(lim.pulse_min)) return;
    servo_now[idx] = v[OUT_W-1:0];
  endfunction

  function automatic void nudge(int idx, int delta);
    store_width(idx, int'(servo_now[idx]) + delta);
  endfunction

  // Graded step of one joystick axis; upper/lower are the dead zone edges
  // of that axis (135/120 for X, 140/115 for Y). The exact gaps at 55, 85,
  // 180 and 210 give no step.
  function automatic int zone_step(logic [7:0] b, int upper, int lower);
    int r;
    int f;
    r = int'(lim.rough_step);
    f = int'(lim.fine_step);
    if (b > 120 && b < 135) return 0;
    if (b > upper) begin
      if (b < 180) return -(f / 2);
      if (b > 180 && b < 210) return -f;
      if (b > 210) return -r;
      return 0;
    end
    if (b > 85 && b < lower) return f / 2;
    if (b > 55 && b < 85) return f;
    if (b < 55) return r;
    return 0;
  endfunction

  function automatic void apply_buttons(logic [7:0] btn);
    int r;
    int g;
    int dx;
    int dy;
    pulse_set_t s;
    r = int'(lim.rough_step);

    // Arm: up wins over down.
    if (btn[BTN_ARM_UP]) begin
      nudge(SRV_ARM_LEFT, r);
      nudge(SRV_ARM_RIGHT, r);
    end else if (btn[BTN_ARM_DOWN]) begin
      nudge(SRV_ARM_LEFT, -r);
      nudge(SRV_ARM_RIGHT, -r);
    end

    // Base rotation: up wins over down.
    if (btn[BTN_TURN_UP]) nudge(SRV_BASE_TURN, r);
    else if (btn[BTN_TURN_DOWN]) nudge(SRV_BASE_TURN, -r);

    // Gripper: close has priority; E+F together opens. Each has its own
    // strict bound on top of the pulse limits.
    if (btn[BTN_CLOSE]) begin
      g = int'(servo_now[SRV_GRIPPER]) - r;
      if (g > int'(lim.gripper_low)) store_width(SRV_GRIPPER, g);
    end else if (btn[BTN_E4] && btn[BTN_E5]) begin
      g = int'(servo_now[SRV_GRIPPER]) + r;
      if (g < int'(lim.gripper_high)) store_width(SRV_GRIPPER, g);
    end

    // Elbow moves only when exactly one of E / F is pressed.
    if (btn[BTN_E4] && !btn[BTN_E5]) nudge(SRV_ELBOW, r);
    else if (btn[BTN_E5] && !btn[BTN_E4]) nudge(SRV_ELBOW, -r);

    dx = zone_step(x_held, 135, 120);
    dy = zone_step(y_held, 140, 115);
    if (dx != 0) nudge(SRV_WRIST_TILT, dx);
    if (dy != 0) nudge(SRV_WRIST_TURN, dy);

    for (int k = 0; k < NUM_SERVOS; k++) s[k] = servo_now[k];
    pulse_sets_due.push_back(s);
  endfunction

  // Advance the frame by one accepted byte.
  function automatic void take_rx_byte(logic [7:0] b);
    case (byte_slot)
      0: begin
        x_held = b;
        byte_slot = 1;
      end
      1: begin
        y_held = b;
        byte_slot = 2;
      end
      default: begin
        byte_slot = 0;
        apply_buttons(b);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the next pending byte once the previous request is gone.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.rx_byte <= '0;
    end else if (!in_chan.valid || byte_taken) begin
      byte_taken = 1'b0;
      if (bytes_pending.size() != 0 && !sender_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        in_chan.valid <= 1'b1;
        in_chan.rx_byte <= bytes_pending.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall the result channel at the phase's rate.
  always @(negedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted byte, check every accepted result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    pulse_set_t got;
    pulse_set_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        take_rx_byte(in_chan.rx_byte);
        byte_taken = 1'b1;
        bytes_seen++;
      end
      if (out_chan.valid && out_chan.ready) begin
        got[SRV_ARM_LEFT] = out_chan.arm_left_pulse;
        got[SRV_ARM_RIGHT] = out_chan.arm_right_pulse;
        got[SRV_BASE_TURN] = out_chan.base_turn_pulse;
        got[SRV_ELBOW] = out_chan.elbow_pulse;
        got[SRV_WRIST_TILT] = out_chan.wrist_tilt_pulse;
        got[SRV_WRIST_TURN] = out_chan.wrist_turn_pulse;
        got[SRV_GRIPPER] = out_chan.gripper_pulse;
        if (pulse_sets_due.size() == 0) begin
          $error("result request with no frame pending");
          failures++;
        end else begin
          want = pulse_sets_due.pop_front();
          frames_checked++;
          for (int k = 0; k < NUM_SERVOS; k++) begin
            if (got[k] !== want[k]) begin
              $error("%s: expected %0d, actual %0d", pulse_names[k], want[k], got[k]);
              failures++;
            end
          end
        end
      end
    end
  end

  // Watchdog: drop out if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Drive the write on a falling edge, mirror it into the predictor. The block
  // is idle whenever this runs, so the timing of the mirror does not matter.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CENTER_PULSE: center_setting = val;
      CFG_PULSE_MIN: lim.pulse_min = val;
      CFG_PULSE_MAX: lim.pulse_max = val;
      CFG_GRIPPER_LOW: lim.gripper_low = val;
      CFG_GRIPPER_HIGH: lim.gripper_high = val;
      CFG_ROUGH_STEP: lim.rough_step = val[STEP_W-1:0];
      CFG_FINE_STEP: lim.fine_step = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] center, logic [CFG_W-1:0] pmin,
                                logic [CFG_W-1:0] pmax, logic [CFG_W-1:0] glow,
                                logic [CFG_W-1:0] ghigh, logic [STEP_W-1:0] rough,
                                logic [STEP_W-1:0] fine);
    write_reg(CFG_CENTER_PULSE, center);
    write_reg(CFG_PULSE_MIN, pmin);
    write_reg(CFG_PULSE_MAX, pmax);
    write_reg(CFG_GRIPPER_LOW, glow);
    write_reg(CFG_GRIPPER_HIGH, ghigh);
    write_reg(CFG_ROUGH_STEP, CFG_W'(rough));
    write_reg(CFG_FINE_STEP, CFG_W'(fine));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_frame(logic [7:0] x, logic [7:0] y, logic [7:0] btn);
    bytes_pending.push_back(x);
    bytes_pending.push_back(y);
    bytes_pending.push_back(btn);
  endtask

  function automatic logic [7:0] pick_axis();
    if ($urandom_range(2) == 0) return axis_edges[$urandom_range(25)];
    return 8'($urandom_range(255));
  endfunction

  // Wait until every byte is in and every result is out, then let the
  // update path drain before touching registers. Check again after the
  // drain, since the last request may only just have been presented.
  task automatic wait_quiet();
    do begin
      while (bytes_pending.size() != 0 || in_chan.valid || pulse_sets_due.size() != 0)
        @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
    end while (bytes_pending.size() != 0 || in_chan.valid ||
               pulse_sets_due.size() != 0 || out_chan.valid);
  endtask

  // Random frames at the given idle and stall rates; optionally park the
  // sender halfway until every outstanding result has come back.
  task automatic run_frames(int frames, int idle_pct, int stall_pct, bit with_pause);
    send_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    for (int n = 0; n < frames; n++)
      queue_frame(pick_axis(), pick_axis(), 8'($urandom_range(255)));
    if (with_pause) begin
      while (bytes_pending.size() > frames * 3 / 2) @(negedge clk);
      sender_hold = 1'b1;
      while (in_chan.valid || pulse_sets_due.size() != 0) @(negedge clk);
      sender_hold = 1'b0;
    end
    wait_quiet();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value from time zero.
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CENTER_PULSE;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.rx_byte = '0;
    out_chan.ready = 1'b0;
    byte_taken = 1'b0;
    sender_hold = 1'b0;
    send_idle_pct = 0;
    ready_stall_pct = 0;
    failures = 0;
    bytes_seen = 0;
    frames_checked = 0;
    settings_used = 0;
    cycle_count = 0;

    // Predictor reset state mirrors the block's reset values.
    center_setting = CENTER_RST;
    lim.pulse_min = PULSE_MIN_RST;
    lim.pulse_max = PULSE_MAX_RST;
    lim.gripper_low = GRIPPER_LOW_RST;
    lim.gripper_high = GRIPPER_HIGH_RST;
    lim.rough_step = ROUGH_STEP_RST;
    lim.fine_step = FINE_STEP_RST;
    byte_slot = 0;
    x_held = '0;
    y_held = '0;
    foreach (servo_now[k]) servo_now[k] = CENTER_RST;

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames on the reset settings: axis extremes and exact gaps,
    // then each button on its own, then both gripper actions.
    settings_used = 1;
    queue_frame(8'd0, 8'd255, 8'h01);     // full outer zones, arm up
    queue_frame(8'd255, 8'd0, 8'h04);     // arm down
    queue_frame(8'd55, 8'd85, 8'h02);     // gap values, turn up
    queue_frame(8'd120, 8'd180, 8'h08);   // gap values, turn down
    queue_frame(8'd210, 8'd115, 8'h10);   // elbow up alone
    queue_frame(8'd135, 8'd140, 8'h20);   // dead zone edges, elbow down alone
    queue_frame(8'd100, 8'd150, 8'h40);   // inner zones, gripper close
    queue_frame(8'd190, 8'd70, 8'h30);    // middle zones, E+F opens gripper
    wait_quiet();

    // Reset values written back explicitly, no idling.
    apply_settings(CENTER_RST, PULSE_MIN_RST, PULSE_MAX_RST, GRIPPER_LOW_RST,
                   GRIPPER_HIGH_RST, ROUGH_STEP_RST, FINE_STEP_RST);
    run_frames(50, 0, 0, 1'b0);

    // Widest limits and largest steps: steps past zero and past full scale
    // must be refused. Sender mostly idle.
    apply_settings(12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 8'd255, 8'd255);
    run_frames(40, 80, 0, 1'b0);

    // Narrow window, odd fine step; receiver mostly stalled, with a full
    // drain of the result channel in the middle.
    apply_settings(12'd2000, 12'd1000, 12'd2000, 12'd1200, 12'd1800, 8'd37, 8'd9);
    run_frames(50, 0, 80, 1'b1);

    // Reversed limits: nothing may move.
    apply_settings(12'd0, 12'd3000, 12'd500, 12'd934, 12'd1680, 8'd10, 8'd3);
    run_frames(20, 24, 24, 1'b0);

    // Zero steps and inverted gripper bounds.
    apply_settings(12'd1500, 12'd0, 12'd4095, 12'd4095, 12'd0, 8'd0, 8'd0);
    run_frames(15, 0, 0, 1'b0);

    // Default window with a coarse rough step so the gripper and arm hit
    // their bounds; fine step of one gives a zero inner step.
    apply_settings(12'd0, PULSE_MIN_RST, PULSE_MAX_RST, GRIPPER_LOW_RST,
                   GRIPPER_HIGH_RST, 8'd128, 8'd1);
    run_frames(50, 24, 24, 1'b0);

    repeat (10) @(negedge clk);
    $display("Ran %0d serial bytes through %0d register settings;", bytes_seen,
             settings_used);
    $display("%0d pulse frames compared, %0d mismatches.", frames_checked, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
